// ----- rtl/mcm_pkg.sv -----
// ----------------------------------------------------------------------------
// mcm_pkg: shared types and codes
// Request and status codes, bank sizes, and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mcm_pkg;

	localparam int REQ_W    = 3;
	localparam int THREAD_W = 4;
	localparam int LOCK_W   = 2;
	localparam int COND_W   = 2;
	localparam int STATUS_W = 4;
	localparam int RESULT_CAP = 16;

	// Bank sizes; the field widths above are sized for them.
	localparam int NUM_THREADS = 16;
	localparam int NUM_LOCKS   = 4;
	localparam int NUM_CONDS   = 4;

	typedef enum logic [REQ_W-1:0] {
		REQ_ACQUIRE   = 3'd0,
		REQ_RELEASE   = 3'd1,
		REQ_WAIT      = 3'd2,
		REQ_SIGNAL    = 3'd3,
		REQ_BROADCAST = 3'd4
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_GRANTED    = 4'd0,
		ST_ALREADY    = 4'd1,
		ST_BLOCKED_LK = 4'd2,
		ST_NOT_OWNER  = 4'd3,
		ST_HANDED     = 4'd4,
		ST_FREED      = 4'd5,
		ST_BLOCKED_CV = 4'd6,
		ST_MOVED      = 4'd7,
		ST_NOTHING    = 4'd8,
		ST_WRONG_LOCK = 4'd9,
		ST_FULL       = 4'd10
	} status_t;

	// Controller commands into the datapath.
	typedef struct packed {
		logic load;        // capture the request fields
		logic rd_lq;       // read lock queue head entry
		logic rd_cq;       // read condition queue head entry
		logic do_acquire;  // acquire decision and update
		logic do_release;  // release using the read head waiter
		logic do_wait_push;// bind condition and push requester
		logic do_wake;     // wake using the read condition head
	} cmd_t;

	// Datapath status into the controller.
	typedef struct packed {
		logic    held;
		logic    owner_is_t;
		logic    bound_ok;      // condition bound to the named lock
		logic    cond_free_ok;  // unbound or bound to the named lock
		logic    cq_full;
		logic    cq_empty;
		logic    lq_empty;
		logic    cq_last;       // condition queue holds exactly one waiter
	} stat_t;

endpackage

// ----- rtl/mcm_if.sv -----
// ----------------------------------------------------------------------------
// mcm_req_if / mcm_rsp_if: request and result channels
// Valid and ready handshake with the payload of one transfer.
// ----------------------------------------------------------------------------
interface mcm_req_if;
	logic                          valid;
	logic                          ready;
	logic [mcm_pkg::REQ_W-1:0]     req_type;
	logic [mcm_pkg::THREAD_W-1:0]  thread_id;
	logic [mcm_pkg::LOCK_W-1:0]    lock_id;
	logic [mcm_pkg::COND_W-1:0]    cond_id;
	modport source (output valid, req_type, thread_id, lock_id, cond_id, input ready);
	modport sink   (input valid, req_type, thread_id, lock_id, cond_id, output ready);
endinterface

interface mcm_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [mcm_pkg::STATUS_W-1:0]  status;
	logic [mcm_pkg::THREAD_W-1:0]  affected_thread;
	logic [mcm_pkg::LOCK_W-1:0]    affected_lock;
	logic                          last;
	modport source (output valid, status, affected_thread, affected_lock, last, input ready);
	modport sink   (input valid, status, affected_thread, affected_lock, last, output ready);
endinterface

// ----- rtl/mcm_ram.sv -----
// ----------------------------------------------------------------------------
// mcm_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mcm_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ----- rtl/mcm_datapath.sv -----
// ----------------------------------------------------------------------------
// mcm_datapath: lock and condition state with the waiter queues
// Holds per-lock and per-condition registers and two waiter RAMs, and
// produces the status code and fields of each result.
// ----------------------------------------------------------------------------
module mcm_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mcm_pkg::cmd_t                  cmd,
	input  logic [mcm_pkg::THREAD_W-1:0]   in_thread,
	input  logic [mcm_pkg::LOCK_W-1:0]     in_lock,
	input  logic [mcm_pkg::COND_W-1:0]     in_cond,
	output mcm_pkg::stat_t                 stat,
	output mcm_pkg::status_t               res_status,
	output logic [mcm_pkg::THREAD_W-1:0]   res_thread,
	output logic [mcm_pkg::LOCK_W-1:0]     res_lock
);
	localparam int NUM_THREADS = mcm_pkg::NUM_THREADS;
	localparam int NUM_LOCKS   = mcm_pkg::NUM_LOCKS;
	localparam int NUM_CONDS   = mcm_pkg::NUM_CONDS;
	localparam int TW = $clog2(NUM_THREADS);
	localparam int LW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
	localparam int CW = (NUM_CONDS > 1) ? $clog2(NUM_CONDS) : 1;
	localparam int NW = TW + 1;

	logic [NUM_LOCKS-1:0]              held_q;
	logic [mcm_pkg::THREAD_W-1:0]      owner_q [NUM_LOCKS];
	logic [TW-1:0]                     lhead_q [NUM_LOCKS];
	logic [NW-1:0]                     lcnt_q  [NUM_LOCKS];
	logic [NUM_CONDS-1:0]              bound_q;
	logic [LW-1:0]                     block_q [NUM_CONDS];
	logic [TW-1:0]                     chead_q [NUM_CONDS];
	logic [NW-1:0]                     ccnt_q  [NUM_CONDS];

	logic [mcm_pkg::THREAD_W-1:0]      t_q;
	logic [LW-1:0]                     l_q;
	logic [CW-1:0]                     c_q;

	// Request fields reduced modulo the bank sizes.
	logic [LW-1:0] l_in;
	logic [CW-1:0] c_in;
	assign l_in = LW'(32'(in_lock) % NUM_LOCKS);
	assign c_in = CW'(32'(in_cond) % NUM_CONDS);

	logic                 lq_we, cq_we;
	logic [LW+TW-1:0]     lq_wa, lq_ra;
	logic [CW+TW-1:0]     cq_wa, cq_ra;
	logic [mcm_pkg::THREAD_W-1:0] lq_wd, cq_wd, lq_rd, cq_rd;

	mcm_ram #(.WIDTH(mcm_pkg::THREAD_W), .DEPTH(NUM_LOCKS * NUM_THREADS)) u_lq (
		.clk(clk), .we(lq_we), .waddr(lq_wa), .wdata(lq_wd), .raddr(lq_ra), .rdata(lq_rd)
	);
	mcm_ram #(.WIDTH(mcm_pkg::THREAD_W), .DEPTH(NUM_CONDS * NUM_THREADS)) u_cq (
		.clk(clk), .we(cq_we), .waddr(cq_wa), .wdata(cq_wd), .raddr(cq_ra), .rdata(cq_rd)
	);

	logic           held, own_t, lfull, cfull;
	logic [TW-1:0]  ltail, ctail;
	assign held  = held_q[l_q];
	assign own_t = held && owner_q[l_q] == t_q;
	assign lfull = lcnt_q[l_q] == NW'(NUM_THREADS);
	assign cfull = ccnt_q[c_q] == NW'(NUM_THREADS);
	assign ltail = lhead_q[l_q] + lcnt_q[l_q][TW-1:0];
	assign ctail = chead_q[c_q] + ccnt_q[c_q][TW-1:0];

	assign lq_ra = {l_q, lhead_q[l_q]};
	assign cq_ra = {c_q, chead_q[c_q]};

	assign stat.held         = held;
	assign stat.owner_is_t   = own_t;
	assign stat.bound_ok     = bound_q[c_q] && block_q[c_q] == l_q;
	assign stat.cond_free_ok = !bound_q[c_q] || block_q[c_q] == l_q;
	assign stat.cq_full      = cfull;
	assign stat.cq_empty     = ccnt_q[c_q] == '0;
	assign stat.lq_empty     = lcnt_q[l_q] == '0;
	assign stat.cq_last      = ccnt_q[c_q] == NW'(1);

	// Pushes: acquire and wake go into the lock RAM, wait into the condition RAM.
	logic wake_to_lq;
	assign wake_to_lq = cmd.do_wake && held && owner_q[l_q] != cq_rd && !lfull;
	assign lq_we = (cmd.do_acquire && held && owner_q[l_q] != t_q && !lfull) || wake_to_lq;
	assign lq_wa = {l_q, ltail};
	assign lq_wd = cmd.do_wake ? cq_rd : t_q;
	assign cq_we = cmd.do_wait_push;
	assign cq_wa = {c_q, ctail};
	assign cq_wd = t_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			t_q <= in_thread;
			l_q <= l_in;
			c_q <= c_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			bound_q <= '0;
			for (int i = 0; i < NUM_LOCKS; i++) begin
				owner_q[i] <= '0;
				lhead_q[i] <= '0;
				lcnt_q[i]  <= '0;
			end
			for (int i = 0; i < NUM_CONDS; i++) begin
				block_q[i] <= '0;
				chead_q[i] <= '0;
				ccnt_q[i]  <= '0;
			end
		end else begin
			if (cmd.do_acquire) begin
				if (!held) begin
					held_q[l_q]  <= 1'b1;
					owner_q[l_q] <= t_q;
				end else if (lq_we) begin
					lcnt_q[l_q] <= lcnt_q[l_q] + 1'b1;
				end
			end
			if (cmd.do_release) begin
				if (lcnt_q[l_q] != '0) begin
					owner_q[l_q] <= lq_rd;
					lhead_q[l_q] <= lhead_q[l_q] + 1'b1;
					lcnt_q[l_q]  <= lcnt_q[l_q] - 1'b1;
				end else begin
					held_q[l_q] <= 1'b0;
				end
			end
			if (cmd.do_wait_push) begin
				bound_q[c_q] <= 1'b1;
				block_q[c_q] <= l_q;
				ccnt_q[c_q]  <= ccnt_q[c_q] + 1'b1;
			end
			if (cmd.do_wake) begin
				// A full lock queue leaves the waiter at the condition head.
				if (held && owner_q[l_q] == cq_rd) begin
					chead_q[c_q] <= chead_q[c_q] + 1'b1;
					ccnt_q[c_q]  <= ccnt_q[c_q] - 1'b1;
				end else if (!held) begin
					held_q[l_q]  <= 1'b1;
					owner_q[l_q] <= cq_rd;
					chead_q[c_q] <= chead_q[c_q] + 1'b1;
					ccnt_q[c_q]  <= ccnt_q[c_q] - 1'b1;
				end else if (!lfull) begin
					lcnt_q[l_q]  <= lcnt_q[l_q] + 1'b1;
					chead_q[c_q] <= chead_q[c_q] + 1'b1;
					ccnt_q[c_q]  <= ccnt_q[c_q] - 1'b1;
				end
			end
		end
	end

	// Result fields for the current command; sampled by the controller.
	always_comb begin
		res_status = mcm_pkg::ST_GRANTED;
		res_thread = t_q;
		res_lock   = mcm_pkg::LOCK_W'(l_q);
		if (cmd.do_acquire) begin
			if (!held)                     res_status = mcm_pkg::ST_GRANTED;
			else if (owner_q[l_q] == t_q)  res_status = mcm_pkg::ST_ALREADY;
			else if (!lfull)               res_status = mcm_pkg::ST_BLOCKED_LK;
			else                           res_status = mcm_pkg::ST_FULL;
		end else if (cmd.do_release) begin
			if (lcnt_q[l_q] != '0) begin
				res_status = mcm_pkg::ST_HANDED;
				res_thread = lq_rd;
			end else begin
				res_status = mcm_pkg::ST_FREED;
			end
		end else if (cmd.do_wake) begin
			res_thread = cq_rd;
			if (held && owner_q[l_q] == cq_rd) res_status = mcm_pkg::ST_ALREADY;
			else if (!held)                    res_status = mcm_pkg::ST_GRANTED;
			else if (lfull)                    res_status = mcm_pkg::ST_FULL;
			else                               res_status = mcm_pkg::ST_MOVED;
		end
	end
endmodule

// ----- rtl/mcm_ctrl.sv -----
// ----------------------------------------------------------------------------
// mcm_ctrl: request sequencer
// Accepts a request, steps the datapath through its queue accesses and
// writes each result into the output register.
// ----------------------------------------------------------------------------
module mcm_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	mcm_req_if.sink                      req,
	mcm_rsp_if.source                    rsp,
	output mcm_pkg::cmd_t                cmd,
	input  mcm_pkg::stat_t               stat,
	input  mcm_pkg::status_t             res_status,
	input  logic [mcm_pkg::THREAD_W-1:0] res_thread,
	input  logic [mcm_pkg::LOCK_W-1:0]   res_lock
);
	typedef enum logic [2:0] {
		S_IDLE, S_DECIDE, S_READ, S_EXEC, S_PUSH, S_OUT
	} state_t;

	state_t                         state_q, next_q;
	mcm_pkg::req_t                  op_q;
	logic [mcm_pkg::THREAD_W-1:0]   t_q;
	logic [4:0]                     n_q;      // execute-step results emitted so far
	logic                           done_q;   // result in register is the last one

	logic take;
	assign req.ready = state_q == S_IDLE;
	assign take      = req.valid && req.ready;

	// Commands for the datapath are decoded from the state.
	always_comb begin
		cmd = '0;
		cmd.load = take;
		if (state_q == S_EXEC) begin
			cmd.do_acquire = op_q == mcm_pkg::REQ_ACQUIRE;
			cmd.do_release = op_q == mcm_pkg::REQ_RELEASE || op_q == mcm_pkg::REQ_WAIT;
			cmd.do_wake    = op_q == mcm_pkg::REQ_SIGNAL || op_q == mcm_pkg::REQ_BROADCAST;
		end
		cmd.do_wait_push = state_q == S_PUSH;
	end

	// Early error checks produce a single final result.
	logic               dec_err;
	mcm_pkg::status_t   dec_code;
	always_comb begin
		dec_err  = 1'b0;
		dec_code = mcm_pkg::ST_NOT_OWNER;
		case (op_q)
			mcm_pkg::REQ_RELEASE: begin
				dec_err = !stat.owner_is_t;
			end
			mcm_pkg::REQ_WAIT: begin
				dec_err = 1'b1;
				if (!stat.owner_is_t)        dec_code = mcm_pkg::ST_NOT_OWNER;
				else if (!stat.cond_free_ok) dec_code = mcm_pkg::ST_WRONG_LOCK;
				else if (stat.cq_full)       dec_code = mcm_pkg::ST_FULL;
				else                         dec_err  = 1'b0;
			end
			mcm_pkg::REQ_SIGNAL, mcm_pkg::REQ_BROADCAST: begin
				dec_err = 1'b1;
				if (!stat.bound_ok)          dec_code = mcm_pkg::ST_WRONG_LOCK;
				else if (!stat.owner_is_t)   dec_code = mcm_pkg::ST_NOT_OWNER;
				else if (stat.cq_empty)      dec_code = mcm_pkg::ST_NOTHING;
				else                         dec_err  = 1'b0;
			end
			default: dec_err = 1'b0;
		endcase
	end

	logic rsp_free, rsp_load, bc_last;
	assign rsp_free = !rsp.valid || rsp.ready;
	// The output register takes a new result in this cycle.
	assign rsp_load = (state_q == S_DECIDE && dec_err && rsp_free) || state_q == S_EXEC
		|| (state_q == S_OUT && rsp_free && op_q == mcm_pkg::REQ_WAIT && next_q == S_IDLE);
	// A broadcast result is final when the wake failed, the cap is reached or
	// this wake empties the condition queue.
	assign bc_last = res_status == mcm_pkg::ST_FULL
		|| n_q == 5'(mcm_pkg::RESULT_CAP - 1) || stat.cq_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			next_q    <= S_IDLE;
			op_q      <= mcm_pkg::REQ_ACQUIRE;
			t_q       <= '0;
			n_q       <= '0;
			done_q    <= 1'b0;
			rsp.valid <= 1'b0;
			rsp.status          <= '0;
			rsp.affected_thread <= '0;
			rsp.affected_lock   <= '0;
			rsp.last            <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready && !rsp_load)
				rsp.valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (take) begin
						t_q <= req.thread_id;
						n_q <= '0;
						if (req.req_type inside {mcm_pkg::REQ_ACQUIRE, mcm_pkg::REQ_RELEASE,
							mcm_pkg::REQ_WAIT, mcm_pkg::REQ_SIGNAL, mcm_pkg::REQ_BROADCAST}) begin
							op_q    <= mcm_pkg::req_t'(req.req_type);
							state_q <= S_DECIDE;
						end
					end
				end
				S_DECIDE: begin
					if (dec_err) begin
						if (rsp_free) begin
							rsp.valid           <= 1'b1;
							rsp.status          <= dec_code;
							rsp.affected_thread <= t_q;
							rsp.affected_lock   <= res_lock;
							rsp.last            <= 1'b1;
							state_q             <= S_IDLE;
						end
					end else begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					// Queue head RAM read settles during this cycle; the step
					// waits here until the output register is free.
					if (rsp_free)
						state_q <= S_EXEC;
				end
				S_EXEC: begin
					rsp.valid           <= 1'b1;
					rsp.status          <= res_status;
					rsp.affected_thread <= res_thread;
					rsp.affected_lock   <= res_lock;
					n_q                 <= n_q + 1'b1;
					if (op_q == mcm_pkg::REQ_WAIT) begin
						rsp.last <= 1'b0;
						next_q   <= S_PUSH;
						done_q   <= 1'b0;
					end else if (op_q == mcm_pkg::REQ_BROADCAST) begin
						rsp.last <= bc_last;
						next_q   <= S_OUT;
						done_q   <= bc_last;
					end else begin
						rsp.last <= 1'b1;
						next_q   <= S_IDLE;
						done_q   <= 1'b1;
					end
					state_q <= S_OUT;
				end
				S_PUSH: begin
					state_q <= S_OUT;
					next_q  <= S_IDLE;
				end
				S_OUT: begin
					if (rsp_free) begin
						if (op_q == mcm_pkg::REQ_WAIT && next_q == S_IDLE) begin
							rsp.valid           <= 1'b1;
							rsp.status          <= mcm_pkg::ST_BLOCKED_CV;
							rsp.affected_thread <= t_q;
							rsp.last            <= 1'b1;
							state_q             <= S_IDLE;
						end else if (op_q == mcm_pkg::REQ_WAIT) begin
							state_q <= S_PUSH;
						end else if (op_q == mcm_pkg::REQ_BROADCAST) begin
							if (done_q)
								state_q <= S_IDLE;
							else
								state_q <= S_READ;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The output register is written only when it is free.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> $stable({rsp.status, rsp.affected_thread,
			rsp.affected_lock, rsp.last}))
		else $error("result overwritten while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		take |-> state_q == S_IDLE)
		else $error("request accepted while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= 5'(mcm_pkg::RESULT_CAP))
		else $error("broadcast exceeded result cap");
endmodule

// ----- rtl/mutex_condvar_manager.sv -----
// ----------------------------------------------------------------------------
// mutex_condvar_manager: mutex and condition variable manager
// An error result is loaded from the decide state; any other request passes
// through the decide, read and execute states before its first result, the
// read state covering the registered queue RAM read. A wait adds a push and
// a second result, and a broadcast repeats read and execute for each wake.
// Reset clears every lock and condition register; the waiter RAMs need no
// clearing since only entries inside a queue's count are ever read.
// ----------------------------------------------------------------------------
module mutex_condvar_manager (
	input logic       clk,
	input logic       arst_n,
	mcm_req_if.sink   req,
	mcm_rsp_if.source rsp
);
	// The controller sequences each request; the datapath holds all lock and condition state.
	mcm_pkg::cmd_t                cmd;
	mcm_pkg::stat_t               stat;
	mcm_pkg::status_t             res_status;
	logic [mcm_pkg::THREAD_W-1:0] res_thread;
	logic [mcm_pkg::LOCK_W-1:0]   res_lock;

	mcm_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.in_thread(req.thread_id), .in_lock(req.lock_id), .in_cond(req.cond_id),
		.stat(stat), .res_status(res_status), .res_thread(res_thread), .res_lock(res_lock)
	);

	mcm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp), .cmd(cmd), .stat(stat),
		.res_status(res_status), .res_thread(res_thread), .res_lock(res_lock)
	);
endmodule

// ----- sim/mcm_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mcm_checker: lock and condition state predictor and result comparator
// Watches request and result transfers, keeps its own copy of every lock
// owner, lock queue and condition queue, and checks each result in order.
// ----------------------------------------------------------------------------
module mcm_checker (
	input  logic     clk,
	input  logic     arst_n,
	mcm_req_if.sink  req_mon,
	mcm_rsp_if.sink  rsp_mon,
	output int       fail_count,
	output int       pending
);

	localparam int NT = mcm_pkg::NUM_THREADS;
	localparam int NL = mcm_pkg::NUM_LOCKS;
	localparam int NC = mcm_pkg::NUM_CONDS;

	typedef struct packed {
		mcm_pkg::status_t status;
		logic [3:0]  thr;
		logic [1:0]  lk;
		logic        last;
	} event_t;

	logic        held [NL];
	logic [3:0]  owner [NL];
	logic [3:0]  lq [NL][NT];
	int          lq_head [NL];
	int          lq_cnt [NL];
	logic        bound [NC];
	logic [1:0]  bound_lk [NC];
	logic [3:0]  cq [NC][NT];
	int          cq_head [NC];
	int          cq_cnt [NC];

	event_t      awaited_events [$];
	event_t      batch [$];

	assign pending = awaited_events.size();

	function automatic void post(mcm_pkg::status_t s, logic [3:0] t, logic [1:0] l);
		event_t e;
		e.status = s;
		e.thr = t;
		e.lk = l;
		e.last = 1'b0;
		batch.push_back(e);
	endfunction

	function automatic void hand_off(int l, logic [3:0] t);
		if (lq_cnt[l] != 0) begin
			owner[l] = lq[l][lq_head[l]];
			lq_head[l] = (lq_head[l] + 1) % NT;
			lq_cnt[l]--;
			post(mcm_pkg::ST_HANDED, owner[l], l[1:0]);
		end else begin
			held[l] = 1'b0;
			post(mcm_pkg::ST_FREED, t, l[1:0]);
		end
	endfunction

	// Moves the head condition waiter onto lock l; zero when the lock queue is full.
	function automatic bit wake_head(int c, int l);
		logic [3:0] w;
		w = cq[c][cq_head[c]];
		if (held[l] && owner[l] == w) begin
			post(mcm_pkg::ST_ALREADY, w, l[1:0]);
		end else if (!held[l]) begin
			held[l] = 1'b1;
			owner[l] = w;
			post(mcm_pkg::ST_GRANTED, w, l[1:0]);
		end else if (lq_cnt[l] >= NT) begin
			post(mcm_pkg::ST_FULL, w, l[1:0]);
			return 1'b0;
		end else begin
			lq[l][(lq_head[l] + lq_cnt[l]) % NT] = w;
			lq_cnt[l]++;
			post(mcm_pkg::ST_MOVED, w, l[1:0]);
		end
		cq_head[c] = (cq_head[c] + 1) % NT;
		cq_cnt[c]--;
		return 1'b1;
	endfunction

	function automatic void predict_request(logic [2:0] op, logic [3:0] t, int l, int c);
		bit owns;
		owns = held[l] && owner[l] == t;
		batch.delete();
		case (op)
			mcm_pkg::REQ_ACQUIRE: begin
				if (!held[l]) begin
					held[l] = 1'b1;
					owner[l] = t;
					post(mcm_pkg::ST_GRANTED, t, l[1:0]);
				end else if (owner[l] == t) post(mcm_pkg::ST_ALREADY, t, l[1:0]);
				else if (lq_cnt[l] < NT) begin
					lq[l][(lq_head[l] + lq_cnt[l]) % NT] = t;
					lq_cnt[l]++;
					post(mcm_pkg::ST_BLOCKED_LK, t, l[1:0]);
				end else post(mcm_pkg::ST_FULL, t, l[1:0]);
			end
			mcm_pkg::REQ_RELEASE: begin
				if (!owns) post(mcm_pkg::ST_NOT_OWNER, t, l[1:0]);
				else hand_off(l, t);
			end
			mcm_pkg::REQ_WAIT: begin
				if (!owns) post(mcm_pkg::ST_NOT_OWNER, t, l[1:0]);
				else if (bound[c] && bound_lk[c] != l) post(mcm_pkg::ST_WRONG_LOCK, t, l[1:0]);
				else if (cq_cnt[c] >= NT) post(mcm_pkg::ST_FULL, t, l[1:0]);
				else begin
					bound[c] = 1'b1;
					bound_lk[c] = l[1:0];
					hand_off(l, t);
					cq[c][(cq_head[c] + cq_cnt[c]) % NT] = t;
					cq_cnt[c]++;
					post(mcm_pkg::ST_BLOCKED_CV, t, l[1:0]);
				end
			end
			mcm_pkg::REQ_SIGNAL, mcm_pkg::REQ_BROADCAST: begin
				if (!bound[c] || bound_lk[c] != l) post(mcm_pkg::ST_WRONG_LOCK, t, l[1:0]);
				else if (!owns) post(mcm_pkg::ST_NOT_OWNER, t, l[1:0]);
				else if (cq_cnt[c] == 0) post(mcm_pkg::ST_NOTHING, t, l[1:0]);
				else if (op == mcm_pkg::REQ_SIGNAL) void'(wake_head(c, l));
				else begin
					while (cq_cnt[c] != 0 && batch.size() < mcm_pkg::RESULT_CAP)
						if (!wake_head(c, l)) break;
				end
			end
			default: ;
		endcase
		if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
		foreach (batch[i]) awaited_events.push_back(batch[i]);
	endfunction

	task automatic report_mismatch(string what);
		$display("MISMATCH at %0t: %s", $time, what);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NL; i++) begin
				held[i] = 1'b0; owner[i] = '0; lq_head[i] = 0; lq_cnt[i] = 0;
			end
			for (int i = 0; i < NC; i++) begin
				bound[i] = 1'b0; bound_lk[i] = '0; cq_head[i] = 0; cq_cnt[i] = 0;
			end
			awaited_events.delete();
			fail_count = 0;
		end else begin
			if (rsp_mon.valid && rsp_mon.ready) begin
				if (awaited_events.size() == 0)
					report_mismatch($sformatf("unexpected result status %0d thread %0d",
						rsp_mon.status, rsp_mon.affected_thread));
				else begin
					event_t e;
					e = awaited_events.pop_front();
					if (rsp_mon.status !== e.status || rsp_mon.affected_thread !== e.thr ||
						rsp_mon.affected_lock !== e.lk || rsp_mon.last !== e.last)
						report_mismatch($sformatf(
							"got st %0d thr %0d lk %0d last %0b, want %0d %0d %0d %0b",
							rsp_mon.status, rsp_mon.affected_thread, rsp_mon.affected_lock,
							rsp_mon.last, e.status, e.thr, e.lk, e.last));
				end
			end
			if (req_mon.valid && req_mon.ready)
				predict_request(req_mon.req_type, req_mon.thread_id,
					req_mon.lock_id, req_mon.cond_id);
		end
	end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: mutex and condition variable manager testbench
// Drives directed and random synchronization requests with random gaps and
// result back-pressure; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending;
	bit   stim_done = 1'b0;

	mcm_req_if req ();
	mcm_rsp_if rsp ();

	mutex_condvar_manager DUT (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	mcm_checker u_checker (
		.clk(clk), .arst_n(arst_n), .req_mon(req), .rsp_mon(rsp),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Sends one request transfer after a random gap. Valid drops only when the
	// next gap is nonzero, so it is never lowered and raised in the same step.
	task automatic send_request(logic [2:0] op, logic [3:0] t, logic [1:0] l, logic [1:0] c);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.req_type <= op;
		req.thread_id <= t;
		req.lock_id <= l;
		req.cond_id <= c;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Waits at the falling edge until every predicted result has arrived.
	task automatic drain_results();
		req.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	// The result side stalls for a random count of cycles per transfer, with
	// long stretches of no stall at all.
	initial begin
		int stall;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 8) : 0;
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
			while (!rsp.valid) @(posedge clk);
		end
	end

	initial begin
		req.valid = 1'b0;
		req.req_type = '0;
		req.thread_id = '0;
		req.lock_id = '0;
		req.cond_id = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: grants, queueing, hand-over, wait and wake paths, errors.
		send_request(mcm_pkg::REQ_ACQUIRE, 4'd0, 2'd0, 2'd0);
		send_request(mcm_pkg::REQ_ACQUIRE, 4'd0, 2'd0, 2'd0);   // already owner
		send_request(mcm_pkg::REQ_ACQUIRE, 4'd15, 2'd0, 2'd0);  // blocked on lock
		send_request(mcm_pkg::REQ_RELEASE, 4'd7, 2'd0, 2'd0);   // not owner
		send_request(mcm_pkg::REQ_SIGNAL, 4'd0, 2'd0, 2'd3);    // unbound condition
		send_request(mcm_pkg::REQ_WAIT, 4'd0, 2'd0, 2'd3);      // hands lock to 15
		send_request(mcm_pkg::REQ_WAIT, 4'd15, 2'd0, 2'd3);     // frees lock
		send_request(mcm_pkg::REQ_ACQUIRE, 4'd9, 2'd3, 2'd0);
		send_request(mcm_pkg::REQ_WAIT, 4'd9, 2'd3, 2'd3);      // wrong lock
		send_request(mcm_pkg::REQ_SIGNAL, 4'd9, 2'd3, 2'd3);    // wrong lock
		send_request(mcm_pkg::REQ_ACQUIRE, 4'd5, 2'd0, 2'd0);
		send_request(mcm_pkg::REQ_SIGNAL, 4'd5, 2'd0, 2'd3);    // moved to lock queue
		send_request(mcm_pkg::REQ_BROADCAST, 4'd5, 2'd0, 2'd3); // moved
		send_request(mcm_pkg::REQ_BROADCAST, 4'd5, 2'd0, 2'd3); // nothing to wake
		send_request(mcm_pkg::REQ_BROADCAST, 4'd6, 2'd0, 2'd3); // not owner
		send_request(3'd7, 4'd5, 2'd0, 2'd3);                   // ignored
		send_request(3'd5, 4'd5, 2'd1, 2'd1);                   // ignored
		send_request(mcm_pkg::REQ_RELEASE, 4'd5, 2'd0, 2'd0);
		send_request(mcm_pkg::REQ_RELEASE, 4'd0, 2'd0, 2'd0);
		send_request(mcm_pkg::REQ_RELEASE, 4'd15, 2'd0, 2'd0);  // freed
		// Fill lock 1 so every other thread is queued, then acquire again as owner.
		for (int i = 0; i < 17; i++)
			send_request(mcm_pkg::REQ_ACQUIRE, i[3:0], 2'd1, 2'd2);
		drain_results();

		// Random: mostly coherent traffic on a few threads, some noise.
		for (int n = 0; n < 85; n++) begin
			logic [2:0] op;
			op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
				: 3'($urandom_range(0, 4));
			send_request(op, 4'($urandom_range(0, ($urandom_range(0, 3) == 0) ? 15 : 5)),
				2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
			if (n == 40) drain_results();
		end
		drain_results();
		stim_done = 1'b1;
	end

	initial begin
		wait (stim_done);
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ----- mutex_condvar_manager.f -----
rtl/mcm_pkg.sv
rtl/mcm_if.sv
rtl/mcm_ram.sv
rtl/mcm_datapath.sv
rtl/mcm_ctrl.sv
rtl/mutex_condvar_manager.sv
sim/mcm_checker.sv
sim/tb.sv
